@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk with asynchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Check prop on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cond at one edge implies cons at the same edge.
`define ASSERT_IMPL(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_IMPL(lbl, cond, cons, msg)
`endif

`endif

@@ rtl/ptst_pkg.sv @@
// ----------------------------------------------------------------------------
// Periodic timer slot table package
// Sizes, request codes and word types shared by the timer slot table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptst_pkg;

    localparam int BACK_SLOTS  = 3;
    localparam int FRONT_SLOTS = 3;
    localparam int MAX_SLOTS   = (BACK_SLOTS > FRONT_SLOTS) ? BACK_SLOTS : FRONT_SLOTS;

    // Slots that exist in each table.
    localparam logic [MAX_SLOTS-1:0] BACK_EN  = MAX_SLOTS'((1 << BACK_SLOTS) - 1);
    localparam logic [MAX_SLOTS-1:0] FRONT_EN = MAX_SLOTS'((1 << FRONT_SLOTS) - 1);

    localparam int KEEP_W   = 3;
    localparam int EXT_W    = MAX_SLOTS + KEEP_W;
    localparam int TICK_W   = 10;
    localparam int REM_W    = 11;
    localparam int HANDLE_W = 8;
    localparam int TIME_W   = 32;

    localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1000);
    localparam logic [REM_W-1:0]  US_PER_MS  = REM_W'(1000);

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_STOP  = 2'd1;
    localparam logic [1:0] REQ_POLL  = 2'd2;

    localparam logic CTX_BACK  = 1'b0;
    localparam logic CTX_FRONT = 1'b1;

    typedef struct packed {
        logic [1:0]          req_type;
        logic                context_req;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   period;
        logic [TIME_W-1:0]   start_time;
        logic [KEEP_W-1:0]   keep_mask;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic [1:0]        slot;
        logic [KEEP_W-1:0] fired_mask;
        logic [TIME_W-1:0] now_us;
        logic [TIME_W-1:0] now_ms;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/periodic_timer_slot_table.sv @@
// ----------------------------------------------------------------------------
// Periodic timer slot table
// Two small tables of periodic timers (back and front context) with start,
// stop and poll requests and a microsecond / millisecond time base.
// ----------------------------------------------------------------------------
// A request is taken on every cycle that start is high; busy stays low, so a
// new request may follow in every cycle. The request word is registered, all
// slots of the chosen table are searched and compared in parallel in the next
// cycle; the result word is registered, and a one-cycle done strobe follows
// through done_reg. The receiver cannot stall: a result must be captured in
// the cycle that done is high. tick_us is written through the cfg channel,
// which is always ready, and should only change while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module periodic_timer_slot_table (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire ptst_pkg::req_t               req,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [ptst_pkg::TICK_W-1:0]  cfg_data,
    output logic                              done,
    output ptst_pkg::res_t                    result
);

    localparam int NS = ptst_pkg::MAX_SLOTS;

    // control state
    logic                           item_valid_reg;
    logic                           done_reg;
    logic [NS-1:0]                  valid_reg [2];
    logic [NS-1:0]                  valid_next [2];
    logic [ptst_pkg::TIME_W-1:0]    time_us_reg, time_us_next;
    logic [ptst_pkg::TIME_W-1:0]    time_ms_reg, time_ms_next;
    logic [ptst_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [ptst_pkg::TICK_W-1:0]    tick_reg;

    // payload
    ptst_pkg::req_t                 item_reg;
    ptst_pkg::res_t                 result_reg, result_next;
    logic [ptst_pkg::HANDLE_W-1:0]  handle_reg [2][NS];
    logic [ptst_pkg::TIME_W-1:0]    period_reg [2][NS];
    logic [ptst_pkg::TIME_W-1:0]    last_reg   [2][NS];

    logic [NS-1:0]                  take_vec;
    logic [NS-1:0]                  fire_vec;
    logic [NS-1:0]                  slot_en;
    logic [ptst_pkg::EXT_W-1:0]     keep_ext;
    logic [ptst_pkg::EXT_W-1:0]     fire_ext;
    logic [ptst_pkg::REM_W-1:0]     rem_sum, rem_once;
    logic [ptst_pkg::TIME_W-1:0]    time_cur;
    logic                           found;
    logic                           ctx;
    logic                           spare_valid;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = result_reg;

    assign ctx      = item_reg.context_req;
    assign slot_en  = (ctx == ptst_pkg::CTX_FRONT) ? ptst_pkg::FRONT_EN : ptst_pkg::BACK_EN;
    assign keep_ext = ptst_pkg::EXT_W'(item_reg.keep_mask);
    assign fire_ext = ptst_pkg::EXT_W'(fire_vec);

    // millisecond carry: remainder stays at most 1000, so two steps suffice
    always_comb
    begin
        rem_sum  = rem_reg + ptst_pkg::REM_W'(tick_reg);
        rem_once = rem_sum;
        rem_next = rem_sum;
        time_ms_next = time_ms_reg;
        if (rem_sum > ptst_pkg::US_PER_MS)
        begin
            rem_once     = rem_sum - ptst_pkg::US_PER_MS;
            rem_next     = rem_once;
            time_ms_next = time_ms_reg + 32'd1;
            if (rem_once > ptst_pkg::US_PER_MS)
            begin
                rem_next     = rem_once - ptst_pkg::US_PER_MS;
                time_ms_next = time_ms_reg + 32'd2;
            end
        end
    end

    always_comb
    begin
        valid_next[0] = valid_reg[0];
        valid_next[1] = valid_reg[1];
        take_vec      = '0;
        fire_vec      = '0;
        found         = 1'b0;
        time_us_next  = time_us_reg;
        time_cur      = time_us_reg;
        result_next   = '0;

        unique case (item_reg.req_type)
            ptst_pkg::REQ_START:
            begin
                // take the lowest free slot
                for (int i = 0; i < NS; i++)
                begin
                    if (!found && slot_en[i] && !valid_reg[ctx][i])
                    begin
                        found            = 1'b1;
                        take_vec[i]      = 1'b1;
                        valid_next[ctx][i] = 1'b1;
                        result_next.slot = 2'(i);
                    end
                end
                result_next.ok = found;
            end
            ptst_pkg::REQ_STOP:
            begin
                // free the lowest valid slot with a matching handle
                for (int i = 0; i < NS; i++)
                begin
                    if (!found && valid_reg[ctx][i] && handle_reg[ctx][i] == item_reg.handle)
                    begin
                        found            = 1'b1;
                        valid_next[ctx][i] = 1'b0;
                        result_next.slot = 2'(i);
                    end
                end
                result_next.ok = found;
            end
            ptst_pkg::REQ_POLL:
            begin
                if (ctx == ptst_pkg::CTX_BACK)
                begin
                    time_cur     = time_us_reg + ptst_pkg::TIME_W'(tick_reg);
                    time_us_next = time_cur;
                end
                for (int i = 0; i < NS; i++)
                begin
                    if (valid_reg[ctx][i] && (time_cur - last_reg[ctx][i]) > period_reg[ctx][i])
                    begin
                        fire_vec[i] = 1'b1;
                        if (!keep_ext[i])
                        begin
                            valid_next[ctx][i] = 1'b0;
                        end
                    end
                end
                result_next.ok         = 1'b1;
                result_next.fired_mask = fire_ext[ptst_pkg::KEEP_W-1:0];
            end
            default:
            begin
                result_next.ok = 1'b0;
            end
        endcase

        result_next.now_us = time_us_next;
        result_next.now_ms = (item_reg.req_type == ptst_pkg::REQ_POLL &&
                              ctx == ptst_pkg::CTX_BACK) ? time_ms_next : time_ms_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            done_reg       <= 1'b0;
            valid_reg[0]   <= '0;
            valid_reg[1]   <= '0;
            time_us_reg    <= '0;
            time_ms_reg    <= '0;
            rem_reg        <= '0;
            tick_reg       <= ptst_pkg::TICK_RESET;
        end
        else
        begin
            item_valid_reg <= start;
            done_reg       <= item_valid_reg;
            if (cfg_valid)
            begin
                tick_reg <= cfg_data;
            end
            if (item_valid_reg)
            begin
                valid_reg[0] <= valid_next[0];
                valid_reg[1] <= valid_next[1];
                time_us_reg  <= time_us_next;
                if (item_reg.req_type == ptst_pkg::REQ_POLL && ctx == ptst_pkg::CTX_BACK)
                begin
                    time_ms_reg <= time_ms_next;
                    rem_reg     <= rem_next;
                end
            end
        end
    end

    // payload words and slot fields carry no reset
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            item_reg <= req;
        end
        if (item_valid_reg)
        begin
            result_reg <= result_next;
            for (int i = 0; i < NS; i++)
            begin
                if (take_vec[i])
                begin
                    handle_reg[ctx][i] <= item_reg.handle;
                    period_reg[ctx][i] <= item_reg.period;
                    last_reg[ctx][i]   <= item_reg.start_time;
                end
                else if (fire_vec[i])
                begin
                    last_reg[ctx][i] <= time_cur;
                end
            end
        end
    end

    assign spare_valid = |(valid_reg[0] & ~ptst_pkg::BACK_EN) |
                         |(valid_reg[1] & ~ptst_pkg::FRONT_EN);

    `ASSERT_IMPL(a_done_follows, start, ##2 done, "result strobe missing two cycles after request")
    `ASSERT_CLK(a_no_spare_slot, !spare_valid, "slot beyond table size marked valid")
    `ASSERT_CLK(a_rem_range, rem_reg <= ptst_pkg::US_PER_MS, "millisecond remainder above 1000")
    `ASSERT_IMPL(a_fail_no_fire, done && !result.ok, result.fired_mask == '0,
                 "failed request reports fired slots")

endmodule

`default_nettype wire
